>>> rtl/kpug_pkg.sv
// ----------------------------------------------------------------------------
// kpug_pkg
// Shared constants, types and codes of the keyed permutation UUID generator.
// ----------------------------------------------------------------------------
`default_nettype none

package kpug_pkg;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned RK_AW  = $clog2(ROUNDS);
  localparam int unsigned WORD_W = 64;

  localparam logic [RK_AW-1:0] RK_FIRST = '0;
  localparam logic [RK_AW-1:0] RK_LAST  = RK_AW'(ROUNDS - 1);

  localparam logic [5:0] TOP6_ZERO   = 6'b00_0000;
  localparam logic [3:0] VERSION_NIB = 4'h4;
  localparam logic [1:0] VARIANT_BITS = 2'b10;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned IN_W   = 128;
  localparam int unsigned RES_W  = 258;
  localparam int unsigned OUT_W  = 264;

  typedef enum logic {
    CMD_GEN   = 1'b0,
    CMD_CHECK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_KEY_LOW    = 2'd0,
    REG_KEY_HIGH   = 2'd1,
    REG_START_LOW  = 2'd2,
    REG_START_HIGH = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic start;
    logic decrypt;
  } cipher_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cipher_sts_t;

endpackage

`default_nettype wire

>>> rtl/kpug_ram.sv
// ----------------------------------------------------------------------------
// kpug_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kpug_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/kpug_keysched.sv
// ----------------------------------------------------------------------------
// kpug_keysched
// Expands the 128-bit key into the round key memory, one round key a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kpug_keysched (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [kpug_pkg::WORD_W-1:0] key_lo_i,
  input  wire logic [kpug_pkg::WORD_W-1:0] key_hi_i,
  output logic                            busy_o,
  output logic                            we_o,
  output logic [kpug_pkg::RK_AW-1:0]      waddr_o,
  output logic [kpug_pkg::WORD_W-1:0]     wdata_o
);

  logic                         busy_q;
  logic [kpug_pkg::RK_AW-1:0]   idx_q;
  logic [kpug_pkg::WORD_W-1:0]  l_q, k_q;
  logic [kpug_pkg::WORD_W-1:0]  l_d, k_d;

  always_comb begin
    l_d = ({l_q[7:0], l_q[63:8]} + k_q) ^ kpug_pkg::WORD_W'(idx_q);
    k_d = {k_q[60:0], k_q[63:61]} ^ l_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= kpug_pkg::RK_FIRST;
      l_q    <= '0;
      k_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= kpug_pkg::RK_FIRST;
      l_q    <= key_lo_i;
      k_q    <= key_hi_i;
    end else if (busy_q) begin
      l_q   <= l_d;
      k_q   <= k_d;
      idx_q <= idx_q + 1'b1;
      if (idx_q == kpug_pkg::RK_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o  = busy_q;
  assign we_o    = busy_q;
  assign waddr_o = idx_q;
  assign wdata_o = k_q;

endmodule

`default_nettype wire

>>> rtl/kpug_cipher.sv
// ----------------------------------------------------------------------------
// kpug_cipher
// Iterative forward and inverse cipher walk, one round a cycle, fetching the
// round keys from the round key memory in the cycle before each round.
// ----------------------------------------------------------------------------
`default_nettype none

module kpug_cipher (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire kpug_pkg::cipher_req_t       req_i,
  input  wire logic [kpug_pkg::WORD_W-1:0] x_i,
  input  wire logic [kpug_pkg::WORD_W-1:0] y_i,
  output kpug_pkg::cipher_sts_t            sts_o,
  output logic [kpug_pkg::WORD_W-1:0]      x_o,
  output logic [kpug_pkg::WORD_W-1:0]      y_o,
  output logic [kpug_pkg::RK_AW-1:0]       rk_raddr_o,
  input  wire logic [kpug_pkg::WORD_W-1:0] rk_rdata_i
);

  logic                        busy_q, done_q, dec_q;
  logic [kpug_pkg::RK_AW-1:0]  addr_q, addr_first, addr_next;
  logic [kpug_pkg::WORD_W-1:0] x_q, y_q, x_d, y_d;
  logic                        pass_end;

  always_comb begin
    addr_first = req_i.decrypt ? kpug_pkg::RK_LAST : kpug_pkg::RK_FIRST;
    if (dec_q) begin
      addr_next = (addr_q == kpug_pkg::RK_FIRST) ? kpug_pkg::RK_LAST : addr_q - 1'b1;
      pass_end  = (addr_q == kpug_pkg::RK_FIRST);
    end else begin
      addr_next = (addr_q == kpug_pkg::RK_LAST) ? kpug_pkg::RK_FIRST : addr_q + 1'b1;
      pass_end  = (addr_q == kpug_pkg::RK_LAST);
    end
  end

  always_comb begin
    if (dec_q) begin
      y_d = {(y_q[2:0] ^ x_q[2:0]), (y_q[63:3] ^ x_q[63:3])};
      x_d = (x_q ^ rk_rdata_i) - y_d;
      x_d = {x_d[55:0], x_d[63:56]};
    end else begin
      x_d = ({x_q[7:0], x_q[63:8]} + y_q) ^ rk_rdata_i;
      y_d = {y_q[60:0], y_q[63:61]} ^ x_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      dec_q  <= 1'b0;
      addr_q <= kpug_pkg::RK_FIRST;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      dec_q  <= req_i.decrypt;
      addr_q <= addr_first;
    end else if (busy_q) begin
      addr_q <= addr_next;
      if (pass_end && (y_d[63:58] == kpug_pkg::TOP6_ZERO)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= x_i;
      y_q <= y_i;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign rk_raddr_o = req_i.start ? addr_first : addr_next;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign x_o        = x_q;
  assign y_o        = y_q;

endmodule

`default_nettype wire

>>> rtl/keyed_permutation_uuid_generator_core.sv
// ----------------------------------------------------------------------------
// keyed_permutation_uuid_generator_core
// Issues version-4 UUIDs by enciphering a counter with a keyed cycle-walking
// permutation, and checks UUIDs by walking the inverse permutation.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  s_axis    in         tvalid/tready       tuser: cmd; tdata: check_high, check_low
//  m_axis    out        tvalid/tready       tdata: uuid_high .. count_high
//  apb       in         psel/penable/pready key_low, key_high, start_low, start_high
//
//  A transaction that walks the cipher runs one or more passes of 32 rounds
//  through the single round unit and its key memory read port. A malformed
//  check goes from idle straight to the result, with no walk.
//  After reset and after every register write the key schedule fills the
//  round key memory, and s_axis_tready_o stays low while it does.
//  A finished result waits in the output register while the next
//  transaction is taken; the walk stalls at its end if that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_permutation_uuid_generator_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // check_high [63:0], check_low [127:64]
  input  wire logic [kpug_pkg::IN_W-1:0]     s_axis_tdata_i,
  // cmd [0]
  input  wire logic                          s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // uuid_high [63:0], uuid_low [127:64], seen [128], well_formed [129],
  // count_low [193:130], count_high [257:194], zero [263:258]
  output logic [kpug_pkg::OUT_W-1:0]         m_axis_tdata_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [kpug_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [kpug_pkg::WORD_W-1:0]   pwdata,
  output logic [kpug_pkg::WORD_W-1:0]        prdata,
  output logic                               pready
);

  localparam int unsigned W = kpug_pkg::WORD_W;

  logic [W-1:0] key_lo_q, key_hi_q, start_lo_q, start_hi_q;
  logic [W-1:0] key_lo_d, key_hi_d, start_lo_d, start_hi_d;
  logic         cfg_wr;
  kpug_pkg::reg_e cfg_idx;

  logic [2*W-1:0] counter_q, counter_d;
  kpug_pkg::state_e state_q, state_d;
  logic           cmd_q, wf_q;
  logic           in_acc, in_gen, well_in, walk_start, out_free, load_out;
  logic           m_valid_q;
  logic [kpug_pkg::RES_W-1:0] out_q, res_d;

  logic                     ks_busy, ks_we;
  logic [kpug_pkg::RK_AW-1:0] ks_waddr, rk_raddr;
  logic [W-1:0]             ks_wdata, rk_rdata;
  kpug_pkg::cipher_req_t    c_req;
  kpug_pkg::cipher_sts_t    c_sts;
  logic [W-1:0]             c_x0, c_y0, c_x, c_y;
  logic                     seen;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = kpug_pkg::reg_e'(paddr[4:3]);

  always_comb begin
    key_lo_d   = key_lo_q;
    key_hi_d   = key_hi_q;
    start_lo_d = start_lo_q;
    start_hi_d = start_hi_q;
    if (cfg_wr) begin
      case (cfg_idx)
        kpug_pkg::REG_KEY_LOW:    key_lo_d   = pwdata;
        kpug_pkg::REG_KEY_HIGH:   key_hi_d   = pwdata;
        kpug_pkg::REG_START_LOW:  start_lo_d = pwdata;
        kpug_pkg::REG_START_HIGH: start_hi_d = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      kpug_pkg::REG_KEY_LOW:    prdata = key_lo_q;
      kpug_pkg::REG_KEY_HIGH:   prdata = key_hi_q;
      kpug_pkg::REG_START_LOW:  prdata = start_lo_q;
      kpug_pkg::REG_START_HIGH: prdata = start_hi_q;
      default:                  prdata = '0;
    endcase
  end

  // Input decode
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_gen  = (s_axis_tuser_i == kpug_pkg::CMD_GEN);
  assign well_in = (s_axis_tdata_i[15:12] == kpug_pkg::VERSION_NIB) &&
                   (s_axis_tdata_i[127:126] == kpug_pkg::VARIANT_BITS);
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    if (in_gen) begin
      c_x0 = counter_q[W-1:0];
      c_y0 = counter_q[2*W-1:W];
    end else begin
      c_x0 = {s_axis_tdata_i[1:0], s_axis_tdata_i[125:64]};
      c_y0 = {kpug_pkg::TOP6_ZERO, s_axis_tdata_i[63:16], s_axis_tdata_i[11:2]};
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      kpug_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_gen || well_in) ? kpug_pkg::ST_RUN : kpug_pkg::ST_FIN;
        end
      end
      kpug_pkg::ST_RUN: begin
        if (c_sts.done) begin
          state_d = kpug_pkg::ST_FIN;
        end
      end
      kpug_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = kpug_pkg::ST_IDLE;
        end
      end
      default: state_d = kpug_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == kpug_pkg::ST_IDLE) && !ks_busy;
    walk_start      = in_acc && (in_gen || well_in);
    load_out        = (state_q == kpug_pkg::ST_FIN) && out_free;
  end

  assign c_req.start   = walk_start;
  assign c_req.decrypt = !in_gen;

  always_comb begin
    counter_d = counter_q;
    if (cfg_wr) begin
      counter_d = {start_hi_d, start_lo_d};
    end else if (in_acc && in_gen) begin
      counter_d = counter_q + 1'b1;
    end
  end

  assign seen = wf_q && ({c_y, c_x} < counter_q);

  always_comb begin
    if (cmd_q == kpug_pkg::CMD_GEN) begin
      res_d = {counter_q[2*W-1:W], counter_q[W-1:0], 1'b0, 1'b0,
               kpug_pkg::VARIANT_BITS, c_x[61:0],
               c_y[57:10], kpug_pkg::VERSION_NIB, c_y[9:0], c_x[63:62]};
    end else begin
      res_d = {counter_q[2*W-1:W], counter_q[W-1:0], wf_q, seen, {(2*W){1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q   <= '0;
      key_hi_q   <= '0;
      start_lo_q <= '0;
      start_hi_q <= '0;
      counter_q  <= '0;
      state_q    <= kpug_pkg::ST_IDLE;
      m_valid_q  <= 1'b0;
    end else begin
      key_lo_q   <= key_lo_d;
      key_hi_q   <= key_hi_d;
      start_lo_q <= start_lo_d;
      start_hi_q <= start_hi_d;
      counter_q  <= counter_d;
      state_q    <= state_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= s_axis_tuser_i;
      wf_q  <= well_in;
    end
    if (load_out) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(kpug_pkg::OUT_W - kpug_pkg::RES_W){1'b0}}, out_q};

  kpug_keysched u_keysched (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cfg_wr),
    .key_lo_i (key_lo_d),
    .key_hi_i (key_hi_d),
    .busy_o   (ks_busy),
    .we_o     (ks_we),
    .waddr_o  (ks_waddr),
    .wdata_o  (ks_wdata)
  );

  kpug_ram #(
    .Width (kpug_pkg::WORD_W),
    .Depth (kpug_pkg::ROUNDS)
  ) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (ks_we),
    .waddr_i (ks_waddr),
    .wdata_i (ks_wdata),
    .raddr_i (rk_raddr),
    .rdata_o (rk_rdata)
  );

  kpug_cipher u_cipher (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (c_req),
    .x_i        (c_x0),
    .y_i        (c_y0),
    .sts_o      (c_sts),
    .x_o        (c_x),
    .y_o        (c_y),
    .rk_raddr_o (rk_raddr),
    .rk_rdata_i (rk_rdata)
  );

  // The key memory is not to be refilled while a walk reads it; the block itself does not enforce this.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_sts.busy |-> !ks_busy)
    else $error("cipher walk overlaps key expansion");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_req.start |-> (state_q == kpug_pkg::ST_IDLE))
    else $error("walk started outside idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kpug_pkg::ST_RUN) |-> (c_sts.busy || c_sts.done))
    else $error("sequencer waits on an idle cipher");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == kpug_pkg::ST_FIN))
    else $error("result presented without a finished transaction");

endmodule

`default_nettype wire
